[design/pmp_pkg.sv]
// ============================================================================
// pmp_pkg
// Types, widths and constants shared by the particle motion predictor.
// ============================================================================
package pmp_pkg;

    localparam int XW         = 32;   // width of every Q16.16 field
    localparam int DT_W       = 21;
    localparam int THR_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [DT_W-1:0]  DT_RESET  = 21'd6554;
    localparam logic [THR_W-1:0] THR_RESET = 17'd66;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP    = 2'd0,
        CFG_STRAIGHT_THR = 2'd1
    } cfg_reg_t;

    // angle to phase conversion, phase in units of 2^-32 turn
    localparam int PHASE_W = 32;
    localparam logic [29:0] TURN_K = 30'd683565276;
    localparam logic [PHASE_W-1:0] PHASE_QUARTER = 32'h4000_0000;

    // sine pipeline
    localparam int SIN_LAT = 6;
    localparam int SIN_Z_W = 31;
    localparam int TRIG_W  = 18;
    localparam logic [SIN_Z_W-1:0] SIN_Q30_ONE = 31'h4000_0000;
    localparam logic [SIN_Z_W-1:0] SIN_C1 = 31'd1686629713;
    localparam logic [SIN_Z_W-1:0] SIN_C3 = 31'd693598668;
    localparam logic [SIN_Z_W-1:0] SIN_C5 = 31'd85569306;
    localparam logic [SIN_Z_W-1:0] SIN_C7 = 31'd5026995;
    localparam logic [SIN_Z_W-1:0] SIN_C9 = 31'd172272;
    localparam logic [SIN_Z_W-1:0] HORNER_COEF [4] = '{SIN_C7, SIN_C5, SIN_C3, SIN_C1};

    // datapath widths
    localparam int PROD_DT_W = XW + DT_W + 1;   // q16 times unsigned dt
    localparam int D_W       = 38;              // rounded distance / heading step
    localparam int SD_W      = 40;              // rounded straight offset
    localparam int DIV_NUM_W = 49;
    localparam int DIV_DEN_W = 32;
    localparam int SUM_W     = 52;

    typedef struct packed {
        logic signed [XW-1:0] pose_x;
        logic signed [XW-1:0] pose_y;
        logic signed [XW-1:0] heading;
        logic signed [XW-1:0] speed;
        logic signed [XW-1:0] turn_rate;
        logic signed [XW-1:0] noise_x;
        logic signed [XW-1:0] noise_y;
        logic signed [XW-1:0] noise_heading;
    } in_item_t;

    typedef struct packed {
        logic signed [XW-1:0] next_x;
        logic signed [XW-1:0] next_y;
        logic signed [XW-1:0] next_heading;
    } out_item_t;

    typedef struct packed {
        logic signed [XW-1:0]   pose_x;
        logic signed [XW-1:0]   pose_y;
        logic signed [XW-1:0]   heading;
        logic signed [XW-1:0]   noise_x;
        logic signed [XW-1:0]   noise_y;
        logic signed [XW-1:0]   noise_heading;
        logic signed [D_W-1:0]  dh;
        logic signed [SD_W-1:0] sdx;
        logic signed [SD_W-1:0] sdy;
        logic                   straight;
        logic                   neg_x;
        logic                   neg_y;
    } div_side_t;

endpackage

[design/particle_motion_predict.sv]
// ============================================================================
// particle_motion_predict
// Constant turn rate and velocity motion step for one particle per item.
// ============================================================================
// Items enter on particle / particle_valid / particle_stall and leave on
// prediction / prediction_valid / prediction_stall; an item moves at an edge
// where valid is high and stall is low. time_step and straight_threshold are
// written on the cfg port (cfg_ready is always high); the user must write
// them only while the block is idle; the block itself does not enforce this.
// The path holds 64 register stages, the first loaded when the item is taken:
// five stages of products and phase conversion, six for the sine pipes,
// three for the offset products and divider setup, 49 for the one bit per
// stage divider, one output register. One item is taken per cycle,
// sustained, while the receiver does not stall the output.
// Reset clears all valid bits and loads the register defaults. When the
// receiver stalls a valid result, the whole pipeline holds and particle_stall
// goes high; nothing is dropped or repeated.
// ============================================================================
module particle_motion_predict
    import pmp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  particle_valid,
    output logic                  particle_stall,
    input  in_item_t              particle,
    output logic                  prediction_valid,
    input  logic                  prediction_stall,
    output out_item_t             prediction,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef struct packed {
        in_item_t              item;
        logic signed [D_W-1:0] d;
        logic signed [D_W-1:0] dh;
        logic                  straight;
    } sin_side_t;

    function automatic logic [XW-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = {{(SUM_W-XW+1){1'b0}}, {(XW-1){1'b1}}};
        lo = {{(SUM_W-XW+1){1'b1}}, {(XW-1){1'b0}}};
        if (v > hi)
        begin
            return {1'b0, {(XW-1){1'b1}}};
        end
        if (v < lo)
        begin
            return {1'b1, {(XW-1){1'b0}}};
        end
        return v[XW-1:0];
    endfunction

    logic [DT_W-1:0]  time_step_reg;
    logic [THR_W-1:0] thr_reg;
    logic             pipe_en;

    logic                        s0_valid_reg;
    in_item_t                    s0_item_reg;
    logic                        s1_valid_reg;
    in_item_t                    s1_item_reg;
    logic signed [PROD_DT_W-1:0] s1_wdt_reg;
    logic signed [PROD_DT_W-1:0] s1_vdt_reg;
    logic                        s1_straight_reg;
    logic                        s2_valid_reg;
    in_item_t                    s2_item_reg;
    logic [63:0]                 s2_a2_reg;
    logic signed [D_W-1:0]       s2_d_reg;
    logic signed [D_W-1:0]       s2_dh_reg;
    logic                        s2_straight_reg;
    logic                        s3_valid_reg;
    sin_side_t                   s3_side_reg;
    logic [29:0]                 s3_pl1_reg;
    logic [PHASE_W-1:0]          s3_ph1_reg;
    logic [29:0]                 s3_pl2_reg;
    logic [PHASE_W-1:0]          s3_ph2_reg;
    logic                        s4_valid_reg;
    sin_side_t                   s4_side_reg;
    logic [PHASE_W-1:0]          s4_ps1_reg;
    logic [PHASE_W-1:0]          s4_pc1_reg;
    logic [PHASE_W-1:0]          s4_ps2_reg;
    logic [PHASE_W-1:0]          s4_pc2_reg;
    logic                        valid_pipe_reg [SIN_LAT];
    sin_side_t                   side_pipe_reg  [SIN_LAT];
    logic                        s5_valid_reg;
    sin_side_t                   s5_side_reg;
    logic signed [TRIG_W:0]      s5_ds_reg;
    logic signed [TRIG_W:0]      s5_dc_reg;
    logic signed [D_W+TRIG_W-1:0] s5_spx_reg;
    logic signed [D_W+TRIG_W-1:0] s5_spy_reg;
    logic                        s6_valid_reg;
    sin_side_t                   s6_side_reg;
    logic signed [XW+TRIG_W:0]   s6_vx_reg;
    logic signed [XW+TRIG_W:0]   s6_vy_reg;
    logic signed [SD_W-1:0]      s6_sdx_reg;
    logic signed [SD_W-1:0]      s6_sdy_reg;
    logic                        s7_valid_reg;
    logic [DIV_NUM_W-1:0]        s7_num_x_reg;
    logic [DIV_NUM_W-1:0]        s7_num_y_reg;
    logic [DIV_DEN_W-1:0]        s7_den_reg;
    div_side_t                   s7_side_reg;
    logic                        out_valid_reg;
    out_item_t                   out_item_reg;

    logic signed [DT_W:0]        dt_s;
    logic signed [PROD_DT_W-1:0] wdt_c;
    logic signed [PROD_DT_W-1:0] vdt_c;
    logic [XW-1:0]               w_mag_c;
    logic                        straight_c;
    logic [63:0]                 th32_c;
    logic [63:0]                 a2_c;
    logic [PROD_DT_W:0]          vround_c;
    logic [PROD_DT_W:0]          wround_c;
    logic [61:0]                 pl1_c;
    logic [PHASE_W-1:0]          ph1_c;
    logic [61:0]                 pl2_c;
    logic [PHASE_W-1:0]          ph2_c;
    logic [PHASE_W-1:0]          phase1_c;
    logic [PHASE_W-1:0]          phase2_c;
    sin_side_t                   s4_side_next;
    logic signed [TRIG_W-1:0]    sin1;
    logic signed [TRIG_W-1:0]    cos1;
    logic signed [TRIG_W-1:0]    sin2;
    logic signed [TRIG_W-1:0]    cos2;
    sin_side_t                   sin_side;
    logic signed [D_W+TRIG_W-1:0] spx_c;
    logic signed [D_W+TRIG_W-1:0] spy_c;
    logic signed [XW+TRIG_W:0]   vx_c;
    logic signed [XW+TRIG_W:0]   vy_c;
    logic [D_W+TRIG_W:0]         sxround_c;
    logic [D_W+TRIG_W:0]         syround_c;
    logic [XW+TRIG_W:0]          vx_mag_c;
    logic [XW+TRIG_W:0]          vy_mag_c;
    logic [DIV_DEN_W-1:0]        den_c;
    div_side_t                   s7_side_next;
    logic                        div_valid;
    logic [DIV_NUM_W-1:0]        quo_x;
    logic [DIV_NUM_W-1:0]        quo_y;
    div_side_t                   div_side;
    logic signed [SUM_W-1:0]     qx_s;
    logic signed [SUM_W-1:0]     qy_s;
    logic signed [SUM_W-1:0]     dx_c;
    logic signed [SUM_W-1:0]     dy_c;
    logic signed [SUM_W-1:0]     dh_c;
    logic signed [SUM_W-1:0]     sum_x_c;
    logic signed [SUM_W-1:0]     sum_y_c;
    logic signed [SUM_W-1:0]     sum_h_c;
    out_item_t                   out_item_next;

    // ------------------------------------------------------------------
    // configuration and flow control
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= DT_RESET;
            thr_reg       <= THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TIME_STEP:    time_step_reg <= cfg_data[DT_W-1:0];
                CFG_STRAIGHT_THR: thr_reg       <= cfg_data[THR_W-1:0];
                default:          ;
            endcase
        end
    end

    // the pipeline advances unless a finished item is held at the output
    assign pipe_en        = !(out_valid_reg && prediction_stall);
    assign particle_stall = !pipe_en;

    // ------------------------------------------------------------------
    // stage 1: turn and distance products, straight decision
    // ------------------------------------------------------------------
    assign dt_s    = $signed({1'b0, time_step_reg});
    assign wdt_c   = s0_item_reg.turn_rate * dt_s;
    assign vdt_c   = s0_item_reg.speed * dt_s;
    assign w_mag_c = s0_item_reg.turn_rate[XW-1] ? (~s0_item_reg.turn_rate + 32'd1)
                                                 : s0_item_reg.turn_rate;
    assign straight_c = (s0_item_reg.turn_rate == '0) ||
                        (w_mag_c < {{(XW-THR_W){1'b0}}, thr_reg});

    // ------------------------------------------------------------------
    // stage 2: second angle in Q32, rounded distance and heading step
    // ------------------------------------------------------------------
    assign th32_c = {{16{s1_item_reg.heading[XW-1]}}, s1_item_reg.heading, 16'h0000};
    assign a2_c   = th32_c + {{(64-PROD_DT_W){s1_wdt_reg[PROD_DT_W-1]}}, s1_wdt_reg};
    // round half away from zero: add half, less one when negative
    assign vround_c = {s1_vdt_reg[PROD_DT_W-1], s1_vdt_reg} + 55'd32768
                      - {{PROD_DT_W{1'b0}}, s1_vdt_reg[PROD_DT_W-1]};
    assign wround_c = {s1_wdt_reg[PROD_DT_W-1], s1_wdt_reg} + 55'd32768
                      - {{PROD_DT_W{1'b0}}, s1_wdt_reg[PROD_DT_W-1]};

    // ------------------------------------------------------------------
    // stage 3: phase products, low 64 bits of angle times turn constant
    // ------------------------------------------------------------------
    assign pl1_c = {s2_item_reg.heading[15:0], 16'h0000} * TURN_K;
    assign ph1_c = {{16{s2_item_reg.heading[XW-1]}}, s2_item_reg.heading[XW-1:16]} * TURN_K;
    assign pl2_c = s2_a2_reg[31:0] * TURN_K;
    assign ph2_c = s2_a2_reg[63:32] * TURN_K;

    // ------------------------------------------------------------------
    // stage 4: phases
    // ------------------------------------------------------------------
    assign phase1_c = {2'b00, s3_pl1_reg} + s3_ph1_reg;
    assign phase2_c = {2'b00, s3_pl2_reg} + s3_ph2_reg;

    always_comb
    begin
        s4_side_next = s3_side_reg;
    end

    // ------------------------------------------------------------------
    // valid chain, stages 0 to 7, sine valid pipe and output valid
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            for (int k = 0; k < SIN_LAT; k++)
            begin
                valid_pipe_reg[k] <= 1'b0;
            end
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s0_valid_reg      <= particle_valid;
            s1_valid_reg      <= s0_valid_reg;
            s2_valid_reg      <= s1_valid_reg;
            s3_valid_reg      <= s2_valid_reg;
            s4_valid_reg      <= s3_valid_reg;
            valid_pipe_reg[0] <= s4_valid_reg;
            for (int k = 1; k < SIN_LAT; k++)
            begin
                valid_pipe_reg[k] <= valid_pipe_reg[k-1];
            end
            s5_valid_reg  <= valid_pipe_reg[SIN_LAT-1];
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            out_valid_reg <= div_valid;
        end
    end

    // ------------------------------------------------------------------
    // payload, stages 0 to 4 and the sine side pipe
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s0_item_reg     <= particle;
            s1_item_reg     <= s0_item_reg;
            s1_wdt_reg      <= wdt_c;
            s1_vdt_reg      <= vdt_c;
            s1_straight_reg <= straight_c;
            s2_item_reg     <= s1_item_reg;
            s2_a2_reg       <= a2_c;
            s2_d_reg        <= vround_c[PROD_DT_W-1:16];
            s2_dh_reg       <= wround_c[PROD_DT_W-1:16];
            s2_straight_reg <= s1_straight_reg;
            s3_side_reg.item     <= s2_item_reg;
            s3_side_reg.d        <= s2_d_reg;
            s3_side_reg.dh       <= s2_dh_reg;
            s3_side_reg.straight <= s2_straight_reg;
            s3_pl1_reg      <= pl1_c[61:32];
            s3_ph1_reg      <= ph1_c;
            s3_pl2_reg      <= pl2_c[61:32];
            s3_ph2_reg      <= ph2_c;
            s4_side_reg     <= s4_side_next;
            s4_ps1_reg      <= phase1_c;
            s4_pc1_reg      <= phase1_c + PHASE_QUARTER;
            s4_ps2_reg      <= phase2_c;
            s4_pc2_reg      <= phase2_c + PHASE_QUARTER;
            side_pipe_reg[0] <= s4_side_reg;
            for (int k = 1; k < SIN_LAT; k++)
            begin
                side_pipe_reg[k] <= side_pipe_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // sine and cosine of both phases
    // ------------------------------------------------------------------
    pmp_sin u_sin1 (.clk(clk), .en(pipe_en), .phase(s4_ps1_reg), .value(sin1));
    pmp_sin u_cos1 (.clk(clk), .en(pipe_en), .phase(s4_pc1_reg), .value(cos1));
    pmp_sin u_sin2 (.clk(clk), .en(pipe_en), .phase(s4_ps2_reg), .value(sin2));
    pmp_sin u_cos2 (.clk(clk), .en(pipe_en), .phase(s4_pc2_reg), .value(cos2));

    assign sin_side = side_pipe_reg[SIN_LAT-1];

    // ------------------------------------------------------------------
    // stages 5 to 7: offsets, straight rounding, divider setup
    // ------------------------------------------------------------------
    assign spx_c = sin_side.d * cos1;
    assign spy_c = sin_side.d * sin1;

    assign vx_c = s5_side_reg.item.speed * s5_ds_reg;
    assign vy_c = s5_side_reg.item.speed * s5_dc_reg;
    assign sxround_c = {s5_spx_reg[D_W+TRIG_W-1], s5_spx_reg} + 57'd32768
                       - {{(D_W+TRIG_W){1'b0}}, s5_spx_reg[D_W+TRIG_W-1]};
    assign syround_c = {s5_spy_reg[D_W+TRIG_W-1], s5_spy_reg} + 57'd32768
                       - {{(D_W+TRIG_W){1'b0}}, s5_spy_reg[D_W+TRIG_W-1]};

    assign vx_mag_c = s6_vx_reg[XW+TRIG_W] ? (~s6_vx_reg + 51'd1) : s6_vx_reg;
    assign vy_mag_c = s6_vy_reg[XW+TRIG_W] ? (~s6_vy_reg + 51'd1) : s6_vy_reg;
    assign den_c    = s6_side_reg.item.turn_rate[XW-1] ? (~s6_side_reg.item.turn_rate + 32'd1)
                                                       : s6_side_reg.item.turn_rate;

    always_comb
    begin
        s7_side_next.pose_x        = s6_side_reg.item.pose_x;
        s7_side_next.pose_y        = s6_side_reg.item.pose_y;
        s7_side_next.heading       = s6_side_reg.item.heading;
        s7_side_next.noise_x       = s6_side_reg.item.noise_x;
        s7_side_next.noise_y       = s6_side_reg.item.noise_y;
        s7_side_next.noise_heading = s6_side_reg.item.noise_heading;
        s7_side_next.dh            = s6_side_reg.dh;
        s7_side_next.sdx           = s6_sdx_reg;
        s7_side_next.sdy           = s6_sdy_reg;
        s7_side_next.straight      = s6_side_reg.straight;
        s7_side_next.neg_x = s6_vx_reg[XW+TRIG_W] ^ s6_side_reg.item.turn_rate[XW-1];
        s7_side_next.neg_y = s6_vy_reg[XW+TRIG_W] ^ s6_side_reg.item.turn_rate[XW-1];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s5_side_reg <= sin_side;
            s5_ds_reg   <= {sin2[TRIG_W-1], sin2} - {sin1[TRIG_W-1], sin1};
            s5_dc_reg   <= {cos1[TRIG_W-1], cos1} - {cos2[TRIG_W-1], cos2};
            s5_spx_reg  <= spx_c;
            s5_spy_reg  <= spy_c;
            s6_side_reg <= s5_side_reg;
            s6_vx_reg   <= vx_c;
            s6_vy_reg   <= vy_c;
            s6_sdx_reg  <= sxround_c[D_W+TRIG_W-1:16];
            s6_sdy_reg  <= syround_c[D_W+TRIG_W-1:16];
            // numerator carries half the divisor for round to nearest
            s7_num_x_reg <= vx_mag_c[DIV_NUM_W-1:0] + {{(DIV_NUM_W-DIV_DEN_W+1){1'b0}},
                                                       den_c[DIV_DEN_W-1:1]};
            s7_num_y_reg <= vy_mag_c[DIV_NUM_W-1:0] + {{(DIV_NUM_W-DIV_DEN_W+1){1'b0}},
                                                       den_c[DIV_DEN_W-1:1]};
            s7_den_reg   <= den_c;
            s7_side_reg  <= s7_side_next;
        end
    end

    pmp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (s7_valid_reg),
        .num_x     (s7_num_x_reg),
        .num_y     (s7_num_y_reg),
        .den       (s7_den_reg),
        .in_side   (s7_side_reg),
        .out_valid (div_valid),
        .quo_x     (quo_x),
        .quo_y     (quo_y),
        .out_side  (div_side)
    );

    // ------------------------------------------------------------------
    // final sums and saturation
    // ------------------------------------------------------------------
    assign qx_s = {{(SUM_W-DIV_NUM_W){1'b0}}, quo_x};
    assign qy_s = {{(SUM_W-DIV_NUM_W){1'b0}}, quo_y};
    assign dx_c = div_side.straight ? {{(SUM_W-SD_W){div_side.sdx[SD_W-1]}}, div_side.sdx}
                                    : (div_side.neg_x ? -qx_s : qx_s);
    assign dy_c = div_side.straight ? {{(SUM_W-SD_W){div_side.sdy[SD_W-1]}}, div_side.sdy}
                                    : (div_side.neg_y ? -qy_s : qy_s);
    // straight motion leaves the heading to the noise alone
    assign dh_c = div_side.straight ? '0 : {{(SUM_W-D_W){div_side.dh[D_W-1]}}, div_side.dh};

    assign sum_x_c = {{(SUM_W-XW){div_side.pose_x[XW-1]}}, div_side.pose_x} + dx_c
                     + {{(SUM_W-XW){div_side.noise_x[XW-1]}}, div_side.noise_x};
    assign sum_y_c = {{(SUM_W-XW){div_side.pose_y[XW-1]}}, div_side.pose_y} + dy_c
                     + {{(SUM_W-XW){div_side.noise_y[XW-1]}}, div_side.noise_y};
    assign sum_h_c = {{(SUM_W-XW){div_side.heading[XW-1]}}, div_side.heading} + dh_c
                     + {{(SUM_W-XW){div_side.noise_heading[XW-1]}}, div_side.noise_heading};

    always_comb
    begin
        out_item_next.next_x       = sat32(sum_x_c);
        out_item_next.next_y       = sat32(sum_y_c);
        out_item_next.next_heading = sat32(sum_h_c);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign prediction_valid = out_valid_reg;
    assign prediction       = out_item_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (prediction_valid && prediction_stall) |-> particle_stall)
        else $error("item taken while output is held");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> ($stable(s7_valid_reg) && $stable(div_valid) && $stable(s4_valid_reg)))
        else $error("pipeline moved during a stall");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(prediction_valid) |-> $past(div_valid))
        else $error("result appeared without a divider item");

    a_zero_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (s7_valid_reg && (s7_den_reg == '0)) |-> s7_side_reg.straight)
        else $error("zero turn rate sent down the arc path");

endmodule

[design/pmp_sin.sv]
// ============================================================================
// pmp_sin
// Six stage sine of a 32-bit phase: quadrant fold, odd polynomial by Horner,
// clamp and round to signed Q16.
// ============================================================================
module pmp_sin
    import pmp_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [PHASE_W-1:0]       phase,
    output logic signed [TRIG_W-1:0] value
);

    localparam int NS = SIN_LAT - 1;

    logic [SIN_Z_W-1:0]     z_reg    [NS];
    logic [SIN_Z_W-1:0]     zz_reg   [NS];
    logic [1:0]             quad_reg [NS];
    logic [SIN_Z_W-1:0]     p_reg    [NS-1];
    logic signed [TRIG_W-1:0] value_reg;

    logic [SIN_Z_W-1:0]     z_c;
    logic [2*SIN_Z_W-1:0]   zz_prod_c;
    logic [2*SIN_Z_W-1:0]   h_prod_c [NS-1];
    logic [SIN_Z_W-1:0]     p_next_c [NS-1];
    logic [2*SIN_Z_W-1:0]   s_prod_c;
    logic [SIN_Z_W:0]       s_c;
    logic [SIN_Z_W-1:0]     s_clamp_c;
    logic [SIN_Z_W-1:0]     s_round_c;
    logic [TRIG_W-1:0]      mag_c;
    logic signed [TRIG_W-1:0] value_next;

    // odd quadrants run the polynomial on the mirrored fraction
    assign z_c = phase[30] ? (SIN_Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
    assign zz_prod_c = z_c * z_c;

    always_comb
    begin
        h_prod_c[0] = zz_reg[0] * SIN_C9;
        p_next_c[0] = HORNER_COEF[0] - h_prod_c[0][2*SIN_Z_W-2:SIN_Z_W-1];
        for (int j = 1; j < NS - 1; j++)
        begin
            h_prod_c[j] = zz_reg[j] * p_reg[j-1];
            p_next_c[j] = HORNER_COEF[j] - h_prod_c[j][2*SIN_Z_W-2:SIN_Z_W-1];
        end
    end

    assign s_prod_c  = z_reg[NS-1] * p_reg[NS-2];
    assign s_c       = s_prod_c[2*SIN_Z_W-1:SIN_Z_W-1];
    assign s_clamp_c = (s_c > {1'b0, SIN_Q30_ONE}) ? SIN_Q30_ONE : s_c[SIN_Z_W-1:0];
    assign s_round_c = s_clamp_c + 31'd8192;
    assign mag_c     = {1'b0, s_round_c[30:14]};
    assign value_next = quad_reg[NS-1][1] ? -mag_c : mag_c;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg[0]    <= z_c;
            zz_reg[0]   <= zz_prod_c[2*SIN_Z_W-2:SIN_Z_W-1];
            quad_reg[0] <= phase[31:30];
            for (int k = 1; k < NS; k++)
            begin
                z_reg[k]    <= z_reg[k-1];
                zz_reg[k]   <= zz_reg[k-1];
                quad_reg[k] <= quad_reg[k-1];
            end
            for (int j = 0; j < NS - 1; j++)
            begin
                p_reg[j] <= p_next_c[j];
            end
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

[design/pmp_div.sv]
// ============================================================================
// pmp_div
// Pipelined restoring divider, one quotient bit per stage, two numerators
// over a shared divisor, with side data carried alongside.
// ============================================================================
module pmp_div
    import pmp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [DIV_NUM_W-1:0] num_x,
    input  logic [DIV_NUM_W-1:0] num_y,
    input  logic [DIV_DEN_W-1:0] den,
    input  div_side_t            in_side,
    output logic                 out_valid,
    output logic [DIV_NUM_W-1:0] quo_x,
    output logic [DIV_NUM_W-1:0] quo_y,
    output div_side_t            out_side
);

    localparam int SW = DIV_DEN_W + DIV_NUM_W;

    logic                 valid_reg [DIV_NUM_W];
    logic [DIV_DEN_W-1:0] rem_x_reg [DIV_NUM_W];
    logic [DIV_DEN_W-1:0] rem_y_reg [DIV_NUM_W];
    logic [DIV_NUM_W-1:0] nq_x_reg  [DIV_NUM_W];
    logic [DIV_NUM_W-1:0] nq_y_reg  [DIV_NUM_W];
    logic [DIV_DEN_W-1:0] den_reg   [DIV_NUM_W];
    div_side_t            side_reg  [DIV_NUM_W];

    logic [SW-1:0] step_x_next [DIV_NUM_W];
    logic [SW-1:0] step_y_next [DIV_NUM_W];

    // numerator bits leave at the top, quotient bits enter at the bottom
    function automatic logic [SW-1:0] div_step(
        input logic [DIV_DEN_W-1:0] rem,
        input logic [DIV_NUM_W-1:0] nq,
        input logic [DIV_DEN_W-1:0] d
    );
        logic [DIV_DEN_W:0] trial;
        logic [DIV_DEN_W:0] diff;
        trial = {rem, nq[DIV_NUM_W-1]};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d})
        begin
            return {diff[DIV_DEN_W-1:0], nq[DIV_NUM_W-2:0], 1'b1};
        end
        return {trial[DIV_DEN_W-1:0], nq[DIV_NUM_W-2:0], 1'b0};
    endfunction

    always_comb
    begin
        step_x_next[0] = div_step('0, num_x, den);
        step_y_next[0] = div_step('0, num_y, den);
        for (int k = 1; k < DIV_NUM_W; k++)
        begin
            step_x_next[k] = div_step(rem_x_reg[k-1], nq_x_reg[k-1], den_reg[k-1]);
            step_y_next[k] = div_step(rem_y_reg[k-1], nq_y_reg[k-1], den_reg[k-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_NUM_W; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < DIV_NUM_W; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_NUM_W; k++)
            begin
                rem_x_reg[k] <= step_x_next[k][SW-1:DIV_NUM_W];
                nq_x_reg[k]  <= step_x_next[k][DIV_NUM_W-1:0];
                rem_y_reg[k] <= step_y_next[k][SW-1:DIV_NUM_W];
                nq_y_reg[k]  <= step_y_next[k][DIV_NUM_W-1:0];
            end
            den_reg[0]  <= den;
            side_reg[0] <= in_side;
            for (int k = 1; k < DIV_NUM_W; k++)
            begin
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[DIV_NUM_W-1];
    assign quo_x     = nq_x_reg[DIV_NUM_W-1];
    assign quo_y     = nq_y_reg[DIV_NUM_W-1];
    assign out_side  = side_reg[DIV_NUM_W-1];

endmodule
